// File: rtl/core/vrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_pkg
// shared constants for the voxel run filter and column extractor
// ----------------------------------------------------------------------------
package vrf_pkg;

  // run and column counters saturate at the top of this width
  localparam int unsigned COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration registers
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_POINTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_COLUMN = 1'd1;
  localparam logic [CFG_W-1:0] MIN_POINTS_RESET = 10'd1;
  localparam logic [CFG_W-1:0] MIN_COLUMN_RESET = 10'd3;

  // record kinds
  localparam logic KIND_VOXEL   = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  // at most this many records come out of one input word
  localparam int unsigned MAX_REC   = 5;
  localparam int unsigned REC_N_W   = 3;
  localparam int unsigned REC_IDX_W = 3;

  // record queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  typedef struct packed {
    logic [CFG_W-1:0] min_points;
    logic [CFG_W-1:0] min_column;
  } vrf_cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/vrf_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_filter
// run and column state, and the records that one key word produces
// ----------------------------------------------------------------------------
module vrf_filter
  import vrf_pkg::*;
#(
  parameter int unsigned KEY_W = 30,
  parameter int unsigned REC_W = 2 * KEY_W + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vrf_cfg_t             cfg,
  input  wire logic                 accept,
  input  wire logic [KEY_W-1:0]     key,
  input  wire logic                 last_point,
  output logic [REC_N_W-1:0]        rec_n,
  output logic [REC_W-1:0]          rec [MAX_REC]
);

  logic [KEY_W-1:0]   run_key_r, run_key_nxt;
  logic [COUNT_W-1:0] run_count_r, run_count_nxt;
  logic               run_open_r, run_open_nxt;
  logic [KEY_W-1:0]   col_first_r, col_first_nxt;
  logic [KEY_W-1:0]   col_last_r, col_last_nxt;
  logic [COUNT_W-1:0] col_len_r, col_len_nxt;
  logic               col_open_r, col_open_nxt;

  always_comb begin
    logic [REC_N_W-1:0] n;
    logic               kept;
    logic [KEY_W-1:0]   kk;

    run_key_nxt   = run_key_r;
    run_count_nxt = run_count_r;
    run_open_nxt  = run_open_r;
    col_first_nxt = col_first_r;
    col_last_nxt  = col_last_r;
    col_len_nxt   = col_len_r;
    col_open_nxt  = col_open_r;
    n             = '0;
    kept          = 1'b0;
    kk            = run_key_r;
    for (int i = 0; i < MAX_REC; i++) begin
      rec[i] = '0;
    end

    // close the previous run when the key moves on
    if (run_open_r && key == run_key_r) begin
      if (run_count_r < COUNT_MAX) begin
        run_count_nxt = run_count_r + COUNT_W'(1);
      end
    end else begin
      kept = run_open_r && (run_count_r >= cfg.min_points);
      if (kept) begin
        kk = run_key_r;
        if (col_open_nxt && ({1'b0, kk} == {1'b0, col_last_nxt} + (KEY_W+1)'(1))) begin
          col_last_nxt = kk;
          if (col_len_nxt < COUNT_MAX) begin
            col_len_nxt = col_len_nxt + COUNT_W'(1);
          end
        end else begin
          if (col_open_nxt && col_len_nxt >= cfg.min_column) begin
            rec[n[REC_IDX_W-1:0]] = {KIND_SEGMENT, col_first_nxt, col_last_nxt, 1'b0};
            n = n + REC_N_W'(1);
          end
          col_open_nxt  = 1'b1;
          col_first_nxt = kk;
          col_last_nxt  = kk;
          col_len_nxt   = COUNT_W'(1);
        end
        rec[n[REC_IDX_W-1:0]] = {KIND_VOXEL, kk, kk, 1'b0};
        n = n + REC_N_W'(1);
      end
      run_key_nxt   = key;
      run_count_nxt = COUNT_W'(1);
      run_open_nxt  = 1'b1;
    end

    // flush of the current run and the open column at the end of the cloud
    if (last_point) begin
      if (run_count_nxt >= cfg.min_points) begin
        kk = run_key_nxt;
        if (col_open_nxt && ({1'b0, kk} == {1'b0, col_last_nxt} + (KEY_W+1)'(1))) begin
          col_last_nxt = kk;
          if (col_len_nxt < COUNT_MAX) begin
            col_len_nxt = col_len_nxt + COUNT_W'(1);
          end
        end else begin
          if (col_open_nxt && col_len_nxt >= cfg.min_column) begin
            rec[n[REC_IDX_W-1:0]] = {KIND_SEGMENT, col_first_nxt, col_last_nxt, 1'b0};
            n = n + REC_N_W'(1);
          end
          col_open_nxt  = 1'b1;
          col_first_nxt = kk;
          col_last_nxt  = kk;
          col_len_nxt   = COUNT_W'(1);
        end
        rec[n[REC_IDX_W-1:0]] = {KIND_VOXEL, kk, kk, 1'b0};
        n = n + REC_N_W'(1);
      end
      if (col_open_nxt && col_len_nxt >= cfg.min_column) begin
        rec[n[REC_IDX_W-1:0]] = {KIND_SEGMENT, col_first_nxt, col_last_nxt, 1'b0};
        n = n + REC_N_W'(1);
      end
      run_open_nxt  = 1'b0;
      run_count_nxt = '0;
      col_open_nxt  = 1'b0;
      col_len_nxt   = '0;
      if (n != '0) begin
        rec[REC_IDX_W'(n - REC_N_W'(1))][0] = 1'b1;
      end
    end

    rec_n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_key_r   <= '0;
      run_count_r <= '0;
      run_open_r  <= 1'b0;
      col_first_r <= '0;
      col_last_r  <= '0;
      col_len_r   <= '0;
      col_open_r  <= 1'b0;
    end else if (accept) begin
      run_key_r   <= run_key_nxt;
      run_count_r <= run_count_nxt;
      run_open_r  <= run_open_nxt;
      col_first_r <= col_first_nxt;
      col_last_r  <= col_last_nxt;
      col_len_r   <= col_len_nxt;
      col_open_r  <= col_open_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vrf_record_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrf_record_fifo
// record queue, up to five writes per cycle and one read per cycle
// ----------------------------------------------------------------------------
module vrf_record_fifo
  import vrf_pkg::*;
#(
  parameter int unsigned REC_W = 62
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [REC_N_W-1:0] push_n,
  input  wire logic [REC_W-1:0]   push_rec [MAX_REC],
  output logic                    room,
  output logic                    head_valid,
  input  wire logic               head_stall,
  output logic [REC_W-1:0]        head_rec
);

  logic [REC_W-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [REC_N_W-1:0]    wr_n;
  logic                  pop;

  // room for a whole word's worth of records
  assign room       = count_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_REC);
  assign head_valid = count_r != '0;
  assign head_rec   = mem_r[rd_ptr_r];
  assign pop        = head_valid && !head_stall;
  assign wr_n       = push ? push_n : '0;

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(wr_n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(wr_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      for (int k = 0; k < MAX_REC; k++) begin
        if (REC_N_W'(k) < wr_n && (wr_ptr_r + FIFO_PTR_W'(k)) == FIFO_PTR_W'(i)) begin
          mem_r[i] <= push_rec[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/voxel_run_filter_column_extract.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_run_filter_column_extract
// run filter over sorted voxel keys with vertical column extraction
// ----------------------------------------------------------------------------
// Takes one sorted voxel key word per cycle while in_stall is low. Runs of
// equal keys are counted (saturating at 1023); a run reaching min_points
// gives an occupied-voxel record, and occupied keys that step by exactly
// one build a column, which gives a segment record when it ends with at
// least min_column voxels. A word with last_point set flushes the open run
// and column and marks its final record with end_of_cloud. The filter state
// updates in the cycle a word is accepted, and its records (zero to five)
// go into an eight-entry record queue that drains one record per cycle
// while out_stall is low. A key word is taken every cycle while the queue
// holds three records or fewer, so the sustained rate is one key per cycle
// as long as keys average at most one record each; otherwise the queue's
// single read port sets the rate at one record per cycle.
// ----------------------------------------------------------------------------
module voxel_run_filter_column_extract
  import vrf_pkg::*;
#(
  parameter int unsigned AXIS_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  // key input words
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [3*AXIS_BITS-1:0] in_voxel_key,
  input  wire logic                   in_last_point,
  // record output words
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_record_kind,
  output logic [3*AXIS_BITS-1:0]      out_first_key,
  output logic [3*AXIS_BITS-1:0]      out_last_key,
  output logic                        out_end_of_cloud
);

  localparam int unsigned KEY_W = 3 * AXIS_BITS;
  localparam int unsigned REC_W = 2 * KEY_W + 2;

  vrf_cfg_t           cfg_r;
  logic               in_accept;
  logic               room;
  logic [REC_N_W-1:0] rec_n;
  logic [REC_W-1:0]   rec [MAX_REC];
  logic [REC_W-1:0]   head_rec;

  // configuration registers, written by the user only while idle; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_points <= MIN_POINTS_RESET;
      cfg_r.min_column <= MIN_COLUMN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_MIN_POINTS: cfg_r.min_points <= cfg_data;
        CFG_IDX_MIN_COLUMN: cfg_r.min_column <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off keys until the queue can take a full word's worth of records
  assign in_stall  = !room;
  assign in_accept = in_valid && room;

  vrf_filter #(
    .KEY_W (KEY_W),
    .REC_W (REC_W)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (in_accept),
    .key        (in_voxel_key),
    .last_point (in_last_point),
    .rec_n      (rec_n),
    .rec        (rec)
  );

  vrf_record_fifo #(
    .REC_W (REC_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_n     (rec_n),
    .push_rec   (rec),
    .room       (room),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head_rec   (head_rec)
  );

  // record layout: kind, first key, last key, end of cloud
  assign out_record_kind  = head_rec[REC_W-1];
  assign out_first_key    = head_rec[REC_W-2 -: KEY_W];
  assign out_last_key     = head_rec[KEY_W:1];
  assign out_end_of_cloud = head_rec[0];

endmodule
`default_nettype wire

// File: dv/vrf_record_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vrf_record_checker
// watches both channels of the voxel run filter, predicts every record word
// from the accepted key words and compares field by field
// ----------------------------------------------------------------------------
module vrf_record_checker
  import vrf_pkg::*;
#(
  parameter int unsigned AXIS_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic [3*AXIS_BITS-1:0] in_voxel_key,
  input  wire logic                   in_last_point,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic                   out_record_kind,
  input  wire logic [3*AXIS_BITS-1:0] out_first_key,
  input  wire logic [3*AXIS_BITS-1:0] out_last_key,
  input  wire logic                   out_end_of_cloud,
  output int                          mismatch_count,
  output int                          records_pending
);

  localparam int unsigned KEY_W = 3 * AXIS_BITS;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic kind;
    key_t first_key;
    key_t last_key;
    logic end_of_cloud;
  } vox_record_t;

  vox_record_t expected_records[$];
  vox_record_t word_records[MAX_REC];
  int          word_count;

  vrf_cfg_t           thresholds;
  key_t               run_key;
  logic [COUNT_W-1:0] run_count;
  logic               run_open;
  key_t               col_first;
  key_t               col_last;
  logic [COUNT_W-1:0] col_length;
  logic               col_open;

  task automatic add_record(input logic kind, input key_t first_key, input key_t last_key);
    word_records[word_count] = '{kind, first_key, last_key, 1'b0};
    word_count++;
  endtask

  task automatic end_column();
    if (col_open && col_length >= thresholds.min_column) begin
      add_record(KIND_SEGMENT, col_first, col_last);
    end
  endtask

  // a kept voxel either stacks on the column or closes it and starts anew
  task automatic keep_voxel(input key_t key);
    logic [KEY_W:0] next_up;
    next_up = {1'b0, col_last} + (KEY_W+1)'(1);
    if (col_open && {1'b0, key} == next_up) begin
      col_last = key;
      if (col_length != COUNT_MAX) col_length++;
    end else begin
      end_column();
      col_open   = 1'b1;
      col_first  = key;
      col_last   = key;
      col_length = COUNT_W'(1);
    end
    add_record(KIND_VOXEL, key, key);
  endtask

  task automatic end_run();
    if (run_open && run_count >= thresholds.min_points) keep_voxel(run_key);
    run_open = 1'b0;
  endtask

  task automatic filter_key(input key_t key, input logic last_point);
    word_count = 0;
    if (run_open && key == run_key) begin
      if (run_count != COUNT_MAX) run_count++;
    end else begin
      end_run();
      run_open  = 1'b1;
      run_key   = key;
      run_count = COUNT_W'(1);
    end
    if (last_point) begin
      end_run();
      end_column();
      run_open   = 1'b0;
      run_count  = '0;
      col_open   = 1'b0;
      col_length = '0;
      if (word_count > 0) word_records[word_count-1].end_of_cloud = 1'b1;
    end
    for (int i = 0; i < word_count; i++) begin
      expected_records.insert(expected_records.size(), word_records[i]);
    end
  endtask

  task automatic compare_field(input string field, input key_t want, input key_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // output words are checked before the key word of the same edge is
  // predicted, since a record never leaves in the cycle of its key
  always @(posedge clk) begin : monitor
    vox_record_t want;
    if (!rst_n) begin
      thresholds = '{MIN_POINTS_RESET, MIN_COLUMN_RESET};
      run_key    = '0;
      run_count  = '0;
      run_open   = 1'b0;
      col_first  = '0;
      col_last   = '0;
      col_length = '0;
      col_open   = 1'b0;
      expected_records.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          $display("%0t ns: unexpected record, expected none actual %s %0d %s %h %s %h %s %0d",
                   $time, "kind", out_record_kind, "first", out_first_key,
                   "last", out_last_key, "eoc", out_end_of_cloud);
          mismatch_count++;
        end else begin
          want = expected_records.pop_front();
          compare_field("record_kind", key_t'(want.kind), key_t'(out_record_kind));
          compare_field("first_key", want.first_key, out_first_key);
          compare_field("last_key", want.last_key, out_last_key);
          compare_field("end_of_cloud", key_t'(want.end_of_cloud), key_t'(out_end_of_cloud));
        end
      end
      if (in_valid && !in_stall) filter_key(in_voxel_key, in_last_point);
      if (cfg_wr_en) begin
        if (cfg_index == CFG_IDX_MIN_POINTS) thresholds.min_points = cfg_data;
        else if (cfg_index == CFG_IDX_MIN_COLUMN) thresholds.min_column = cfg_data;
      end
    end
    records_pending = expected_records.size();
  end

endmodule

// File: dv/tb_voxel_run_filter_column_extract.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_run_filter_column_extract
// feeds sorted voxel key clouds through the run filter under random idling
// and back-pressure; a side checker predicts and compares every record word
// ----------------------------------------------------------------------------
module tb_voxel_run_filter_column_extract
  import vrf_pkg::*;
;

  localparam int unsigned AXIS_BITS      = 10;
  localparam int unsigned KEY_W          = 3 * AXIS_BITS;
  localparam int unsigned RESET_CYCLES   = 9;
  // records leave the queue after their key is taken, the queue holds eight
  localparam int unsigned SETTLE_CYCLES  = 16;
  // long receiver hold-off, well past what fills the record queue
  localparam int unsigned HOLD_CYCLES    = 300;
  // longest quiet stretch of a correct run is the hold-off above plus a
  // few bursts and a settle pause, so this leaves ample margin
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_WORDS    = 55;
  localparam logic [KEY_W-1:0] TOP_KEY   = {KEY_W{1'b1}};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [KEY_W-1:0]     in_voxel_key;
  logic                 in_last_point;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_record_kind;
  logic [KEY_W-1:0]     out_first_key;
  logic [KEY_W-1:0]     out_last_key;
  logic                 out_end_of_cloud;

  int mismatch_count;
  int records_pending;

  // quiet turns off idling on both sides for the closing stretch
  bit quiet         = 1'b0;
  // each increment asks the receiver for one long hold-off
  int hold_requests = 0;
  int calm_words    = 0;
  int idle_cycles;

  always #6 clk = ~clk;

  voxel_run_filter_column_extract #(
    .AXIS_BITS(AXIS_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_voxel_key    (in_voxel_key),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_first_key   (out_first_key),
    .out_last_key    (out_last_key),
    .out_end_of_cloud(out_end_of_cloud)
  );

  vrf_record_checker #(
    .AXIS_BITS(AXIS_BITS)
  ) u_record_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_voxel_key    (in_voxel_key),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_first_key   (out_first_key),
    .out_last_key    (out_last_key),
    .out_end_of_cloud(out_end_of_cloud),
    .mismatch_count  (mismatch_count),
    .records_pending (records_pending)
  );

  // x in the top field, z in the low field
  function automatic logic [KEY_W-1:0] pack_key(input int unsigned x, input int unsigned y,
                                                input int unsigned z);
    return {AXIS_BITS'(x), AXIS_BITS'(y), AXIS_BITS'(z)};
  endfunction

  // mostly short runs of equal keys, now and then a longer one
  function automatic int unsigned run_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
  endfunction

  // one key word; an optional idle burst first, then hold until accepted
  task automatic send_word(input logic [KEY_W-1:0] key, input logic last_point);
    int gap;
    gap = 0;
    if (!quiet) begin
      if (calm_words > 0) begin
        calm_words--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: gap = $urandom_range(1, 17);
          2: calm_words = $urandom_range(10, 40);
          default: ;
        endcase
      end
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_voxel_key  = key;
    in_last_point = last_point;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // sender pauses until every record has left, then lets the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (records_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index, input int unsigned value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = reg_index;
    cfg_data  = CFG_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_thresholds(input int unsigned points, input int unsigned column);
    write_reg(CFG_IDX_MIN_POINTS, points);
    write_reg(CFG_IDX_MIN_COLUMN, column);
  endtask

  // clouds of ascending keys: runs of equal keys, mostly unit steps so that
  // columns form, some larger steps and jumps, a little out-of-order noise;
  // every cloud closes with last_point
  task automatic random_phase(input int unsigned words);
    logic [KEY_W-1:0] cursor;
    int unsigned      cloud_left;
    int unsigned      run_left;
    int unsigned      roll;
    while (words > 0) begin
      cloud_left = $urandom_range(3, 24);
      if (cloud_left > words) cloud_left = words;
      words -= cloud_left;
      case ($urandom_range(0, 5))
        // start near the top key to probe the no-wrap rule
        0: cursor = TOP_KEY - KEY_W'($urandom_range(0, 6));
        // start just below a z carry into the next y
        1: cursor = pack_key($urandom, $urandom, 1023 - $urandom_range(0, 4));
        default: cursor = KEY_W'($urandom);
      endcase
      run_left = run_length();
      while (cloud_left > 0) begin
        cloud_left--;
        send_word(cursor, cloud_left == 0);
        run_left--;
        if (run_left == 0) begin
          run_left = run_length();
          roll     = $urandom_range(0, 9);
          if (roll < 6) cursor = cursor + KEY_W'(1);
          else if (roll < 8) cursor = cursor + KEY_W'($urandom_range(2, 5));
          else if (roll < 9) cursor = cursor + KEY_W'($urandom_range(1024, 1 << 20));
          else cursor = KEY_W'($urandom);
        end
      end
    end
  endtask

  // receiver: random stall bursts, calm stretches, and the long hold-off
  initial begin : receiver
    int stall_left;
    int calm_left;
    int hold_left;
    int holds_done;
    out_stall  = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (calm_left > 0) begin
        out_stall = 1'b0;
        calm_left--;
      end else begin
        case ($urandom_range(0, 9))
          // stall now, and keep stalling while stall_left counts down
          0: begin
            stall_left = $urandom_range(0, 16);
            out_stall  = 1'b1;
          end
          1: begin
            calm_left = $urandom_range(20, 80);
            out_stall = 1'b0;
          end
          default: out_stall = 1'b0;
        endcase
      end
    end
  end

  // watchdog: too long with no word moving on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_IDX_MIN_POINTS;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_voxel_key  = '0;
    in_last_point = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset thresholds: one point keeps a voxel, three voxels make a segment
    send_word(pack_key(0, 0, 0), 1'b0);
    send_word(pack_key(0, 0, 0), 1'b0);
    send_word(pack_key(0, 0, 1), 1'b0);
    send_word(pack_key(0, 0, 2), 1'b0);
    send_word(pack_key(0, 0, 3), 1'b0);
    // column of four breaks here: segment word ahead of the voxel word
    send_word(pack_key(3, 4, 1022), 1'b0);
    send_word(pack_key(3, 4, 1023), 1'b0);
    // z carry into the next y still stacks
    send_word(pack_key(3, 5, 0), 1'b0);
    send_word(pack_key(3, 5, 0), 1'b0);
    send_word(pack_key(3, 5, 9), 1'b0);
    // out-of-order key closes the run
    send_word(pack_key(1, 1, 1), 1'b0);
    send_word(TOP_KEY - KEY_W'(1), 1'b0);
    send_word(TOP_KEY, 1'b0);
    // key zero after the top key must not stack
    send_word(pack_key(0, 0, 0), 1'b0);
    send_word(pack_key(0, 0, 0), 1'b1);
    wait_idle();

    // zero thresholds keep every run and let every column give a segment
    set_thresholds(0, 0);
    send_word(pack_key(9, 9, 9), 1'b0);
    send_word(pack_key(9, 9, 10), 1'b0);
    send_word(pack_key(9, 9, 10), 1'b0);
    send_word(pack_key(20, 0, 0), 1'b1);
    wait_idle();

    // a last word that keeps nothing gives no word at all
    set_thresholds(1023, 1023);
    send_word(pack_key(1, 2, 3), 1'b1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) set_thresholds(1, 1);
      // single-point voxels fill the record queue during the hold-off
      else if (p == 1) set_thresholds(1, 2);
      else if (p == RANDOM_PHASES - 1) set_thresholds(2, 3);
      else set_thresholds($urandom_range(1, 3), $urandom_range(2, 5));
      if (p == 1) hold_requests++;
      if (p == RANDOM_PHASES - 1) quiet = 1'b1;
      random_phase(PHASE_WORDS);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/vrf_pkg.sv
rtl/core/vrf_filter.sv
rtl/core/vrf_record_fifo.sv
rtl/core/voxel_run_filter_column_extract.sv
dv/vrf_record_checker.sv
dv/tb_voxel_run_filter_column_extract.sv
